FILE: src/sotc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotc_pkg: shared types and helpers for the strict order closure table
// Sizes of the closure matrix, the name and set fields, the operation codes
// and the transfer that walks the chain of row cells.
// ----------------------------------------------------------------------------
package sotc_pkg;

  // Number of names, and thus of rows and of columns per row (2 to 16)
  localparam int NAMES  = 16;
  localparam int IDX_W  = $clog2(NAMES);
  localparam int NAME_W = 4;
  localparam int SET_W  = 16;
  localparam int KIND_W = 3;

  typedef logic [NAMES-1:0]  row_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [NAME_W-1:0] name_t;
  typedef logic [SET_W-1:0]  set_t;

  // Set bits that address a real row
  localparam set_t SET_LIVE = set_t'({NAMES{1'b1}});

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    K_ADD_PAIR   = 3'd0,
    K_ADD_SET    = 3'd1,
    K_RENAME     = 3'd2,
    K_REMOVE     = 3'd3,
    K_QUERY_PAIR = 3'd4,
    K_QUERY_KEY  = 3'd5
  } kind_e;

  // Transfer that walks the cell chain: row edits applied in order
  // (add1, trim, add2, drop), then capture of up to two rows.
  typedef struct packed {
    logic valid;
    logic do_add1;   // name_a gains mask1, as do rows holding name_a
    logic do_trim;   // row name_a loses column name_b
    logic do_add2;   // name_b gains mask2, as do rows holding name_b
    logic do_drop;   // name_a removed: row, present flag and column
    idx_t name_a;
    idx_t name_b;
    row_t mask1;
    row_t mask2;
    idx_t cap_x;
    idx_t cap_y;
    row_t row_x;
    row_t row_y;
    logic pres_x;
    logic pres_y;
  } pkt_t;

  function automatic logic name_ok(name_t n);
    return int'(n) < NAMES;
  endfunction

  function automatic idx_t to_idx(name_t n);
    return idx_t'(n);
  endfunction

  function automatic row_t one_hot(idx_t i);
    return row_t'(1) << i;
  endfunction

endpackage

FILE: src/strict_order_closure_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_order_closure_table: transitively closed strict order over names
// Operation channel in (kind, first_name, second_name, name_set), one result
// per operation out (success, still_sortable, found, present_rows).
//
// One operation at a time: in_stall_o is high from the transfer until the
// result is in the output register. The result register lets the next
// operation in while a result still waits under out_stall_i.
// Every row access is a transfer walking the chain of NAMES cells, one cell
// per cycle. A query key, an undefined kind and an early failure need no
// walk; a query pair and a remove take one walk, an add pair and a rename at
// most two, and an add set at most two for each right name that it adds.
// Reset clears every row, every present flag and sets sortable; no clearing
// pass is needed. While the receiver stalls, the result holds in the output
// register and at most one further operation is taken and then held.
// ----------------------------------------------------------------------------
module strict_order_closure_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sotc_pkg::KIND_W-1:0] kind_i,
  input  logic [sotc_pkg::NAME_W-1:0] first_name_i,
  input  logic [sotc_pkg::NAME_W-1:0] second_name_i,
  input  logic [sotc_pkg::SET_W-1:0]  name_set_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        success_o,
  output logic                        still_sortable_o,
  output logic                        found_o,
  output logic [sotc_pkg::SET_W-1:0]  present_rows_o
);

  sotc_pkg::pkt_t               chain [sotc_pkg::NAMES+1];
  sotc_pkg::row_t               present;
  logic [sotc_pkg::NAMES:0]     chain_valid;

  // Sequencer
  sotc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .first_name_i     (first_name_i),
    .second_name_i    (second_name_i),
    .name_set_i       (name_set_i),
    .pkt_o            (chain[0]),
    .ret_i            (chain[sotc_pkg::NAMES]),
    .present_i        (present),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .success_o        (success_o),
    .still_sortable_o (still_sortable_o),
    .found_o          (found_o),
    .present_rows_o   (present_rows_o)
  );

  // Row cells, one per name
  for (genvar i = 0; i < sotc_pkg::NAMES; i++) begin : g_cell
    sotc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (sotc_pkg::idx_t'(i)),
      .pkt_i  (chain[i]),
      .pkt_o  (chain[i+1]),
      .pres_o (present[i])
    );
  end

  always_comb begin
    for (int i = 0; i <= sotc_pkg::NAMES; i++) chain_valid[i] = chain[i].valid;
  end

`ifndef SYNTH
  // At most one transfer in the chain at any time
  a_one_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_valid) <= 1)
    else $error("more than one transfer in the chain");
`endif

endmodule

FILE: src/sotc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotc_cell: one row of the closure matrix
// Holds one row and its present flag, applies the edits carried by the
// passing transfer, captures its row on request and hands the transfer on.
// ----------------------------------------------------------------------------
module sotc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sotc_pkg::idx_t  idx_i,
  input  sotc_pkg::pkt_t  pkt_i,
  output sotc_pkg::pkt_t  pkt_o,
  output logic            pres_o
);

  sotc_pkg::row_t row_q, row_d;
  logic           pres_q, pres_d;
  sotc_pkg::pkt_t pkt_q, pkt_d;
  logic           hit1, hit2;

  // Row edits in the order of the transfer, then capture
  always_comb begin
    row_d  = row_q;
    pres_d = pres_q;
    pkt_d  = pkt_i;
    hit1   = 1'b0;
    hit2   = 1'b0;
    if (pkt_i.valid) begin
      if (pkt_i.do_add1) begin
        hit1 = (idx_i == pkt_i.name_a) || (pres_d && row_d[pkt_i.name_a]);
        if (idx_i == pkt_i.name_a) begin
          if (!pres_d) row_d = '0;
          pres_d = 1'b1;
        end
        if (hit1) row_d = row_d | pkt_i.mask1;
      end
      if (pkt_i.do_trim && (idx_i == pkt_i.name_a)) begin
        row_d = row_d & ~sotc_pkg::one_hot(pkt_i.name_b);
      end
      if (pkt_i.do_add2) begin
        hit2 = (idx_i == pkt_i.name_b) || (pres_d && row_d[pkt_i.name_b]);
        if (idx_i == pkt_i.name_b) begin
          if (!pres_d) row_d = '0;
          pres_d = 1'b1;
        end
        if (hit2) row_d = row_d | pkt_i.mask2;
      end
      if (pkt_i.do_drop) begin
        if (idx_i == pkt_i.name_a) begin
          row_d  = '0;
          pres_d = 1'b0;
        end
        row_d = row_d & ~sotc_pkg::one_hot(pkt_i.name_a);
      end
      if (idx_i == pkt_i.cap_x) begin
        pkt_d.row_x  = row_d;
        pkt_d.pres_x = pres_d;
      end
      if (idx_i == pkt_i.cap_y) begin
        pkt_d.row_y  = row_d;
        pkt_d.pres_y = pres_d;
      end
    end
  end

  // Row state and the hop register to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      pres_q      <= 1'b0;
      pkt_q.valid <= 1'b0;
    end else begin
      row_q  <= row_d;
      pres_q <= pres_d;
      pkt_q  <= pkt_d;
    end
  end

  assign pkt_o  = pkt_q;
  assign pres_o = pres_q;

`ifndef SYNTH
  // A name without a row keeps an all-zero row
  a_absent_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pres_q |-> (row_q == '0))
    else $error("absent row holds bits");
`endif

endmodule

FILE: src/sotc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotc_ctrl: operation sequencer for the closure table
// Takes one operation, launches gather and update transfers into the cell
// chain, decides on each returning transfer and registers the result.
// ----------------------------------------------------------------------------
module sotc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // operation channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sotc_pkg::KIND_W-1:0] kind_i,
  input  sotc_pkg::name_t            first_name_i,
  input  sotc_pkg::name_t            second_name_i,
  input  sotc_pkg::set_t             name_set_i,
  // cell chain
  output sotc_pkg::pkt_t             pkt_o,
  input  sotc_pkg::pkt_t             ret_i,
  input  sotc_pkg::row_t             present_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       success_o,
  output logic                       still_sortable_o,
  output logic                       found_o,
  output sotc_pkg::set_t             present_rows_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    PH_GATHER = 2'b01,
    PH_UPDATE = 2'b10
  } phase_e;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  sotc_pkg::kind_e  kind_q;
  sotc_pkg::name_t  a_q, b_q, cur_q, cur_d;
  sotc_pkg::set_t   set_q, set_d;
  logic             sort_q;
  logic             fin_ok_q, fin_found_q;
  sotc_pkg::pkt_t   pkt_q, pkt_d;

  logic             out_valid_q, out_success_q, out_sort_q, out_found_q;
  sotc_pkg::set_t   out_pres_q;

  logic             decide, begin_ph;
  logic             issue, fin, fin_ok, fin_found, clr;
  logic             a_ok, b_ok;
  sotc_pkg::idx_t   ai, bi, ci;
  logic             low_any;
  sotc_pkg::name_t  low_idx;
  logic             has_ab, has_ba;
  sotc_pkg::row_t   add1, add2, rowa;
  logic             out_free;

  assign decide   = (state_q == ST_START) || ((state_q == ST_WALK) && ret_i.valid);
  assign begin_ph = (state_q == ST_START);
  assign a_ok     = sotc_pkg::name_ok(a_q);
  assign b_ok     = sotc_pkg::name_ok(b_q);
  assign ai       = sotc_pkg::to_idx(a_q);
  assign bi       = sotc_pkg::to_idx(b_q);
  assign ci       = sotc_pkg::to_idx(cur_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Lowest pending right name of an add set
  always_comb begin
    low_any = 1'b0;
    low_idx = '0;
    for (int i = sotc_pkg::SET_W - 1; i >= 0; i--) begin
      if (set_q[i]) begin
        low_any = 1'b1;
        low_idx = sotc_pkg::name_t'(i);
      end
    end
  end

  // Rename masks from the two gathered rows
  always_comb begin
    has_ab = ret_i.pres_x && ret_i.row_x[bi];
    has_ba = ret_i.pres_y && ret_i.row_y[ai];
    add1   = sotc_pkg::one_hot(bi) | (ret_i.pres_y ? ret_i.row_y : '0);
    rowa   = ((ret_i.pres_x ? ret_i.row_x : '0) | add1) & ~sotc_pkg::one_hot(bi);
    add2   = sotc_pkg::one_hot(ai) | rowa;
  end

  // Decision on start and on each returning transfer
  always_comb begin
    issue     = 1'b0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    fin_found = 1'b0;
    clr       = 1'b0;
    set_d     = set_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    pkt_d     = '0;
    if (decide) begin
      unique case (kind_q) inside
        sotc_pkg::K_ADD_PAIR, sotc_pkg::K_ADD_SET: begin
          if (begin_ph && (!a_ok || ((kind_q == sotc_pkg::K_ADD_PAIR) && !b_ok))) begin
            fin = 1'b1;
          end else if (begin_ph || (phase_q == PH_UPDATE)) begin
            // next right name, or done
            if (!low_any) begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end else if (!sort_q) begin
              fin = 1'b1;
            end else begin
              issue       = 1'b1;
              pkt_d.cap_x = sotc_pkg::to_idx(low_idx);
              cur_d       = low_idx;
              set_d       = set_q & ~(sotc_pkg::set_t'(1) << low_idx);
              phase_d     = PH_GATHER;
            end
          end else begin
            // right's row gathered: check for a reverse pair
            if ((cur_q == a_q) || (ret_i.pres_x && ret_i.row_x[ai])) begin
              clr = 1'b1;
              fin = 1'b1;
            end else begin
              issue         = 1'b1;
              pkt_d.do_add1 = 1'b1;
              pkt_d.name_a  = ai;
              pkt_d.mask1   = sotc_pkg::one_hot(ci) | (ret_i.pres_x ? ret_i.row_x : '0);
              phase_d       = PH_UPDATE;
            end
          end
        end
        sotc_pkg::K_RENAME: begin
          if (begin_ph) begin
            if (!a_ok || !b_ok || !sort_q) begin
              fin = 1'b1;
            end else begin
              issue       = 1'b1;
              pkt_d.cap_x = ai;
              pkt_d.cap_y = bi;
              phase_d     = PH_GATHER;
            end
          end else if (phase_q == PH_GATHER) begin
            if (has_ab || has_ba || (a_q == b_q)) begin
              clr = 1'b1;
              fin = 1'b1;
            end else begin
              // both adds, the trim and the removal in one walk
              issue         = 1'b1;
              pkt_d.do_add1 = 1'b1;
              pkt_d.do_trim = 1'b1;
              pkt_d.do_add2 = 1'b1;
              pkt_d.do_drop = 1'b1;
              pkt_d.name_a  = ai;
              pkt_d.name_b  = bi;
              pkt_d.mask1   = add1;
              pkt_d.mask2   = add2;
              phase_d       = PH_UPDATE;
            end
          end else begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end
        end
        sotc_pkg::K_REMOVE: begin
          if (begin_ph) begin
            if (!a_ok || !sort_q) begin
              fin = 1'b1;
            end else begin
              issue         = 1'b1;
              pkt_d.do_drop = 1'b1;
              pkt_d.name_a  = ai;
              phase_d       = PH_UPDATE;
            end
          end else begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end
        end
        sotc_pkg::K_QUERY_PAIR: begin
          if (begin_ph) begin
            if (!a_ok || !b_ok) begin
              fin = 1'b1;
            end else begin
              issue       = 1'b1;
              pkt_d.cap_x = ai;
              phase_d     = PH_GATHER;
            end
          end else begin
            fin       = 1'b1;
            fin_found = ret_i.pres_x && ret_i.row_x[bi];
            fin_ok    = fin_found;
          end
        end
        sotc_pkg::K_QUERY_KEY: begin
          fin       = 1'b1;
          fin_found = a_ok && present_i[ai];
          fin_ok    = fin_found;
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
    pkt_d.valid = issue;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_START;
      ST_START,
      ST_WALK: begin
        if (issue)    state_d = ST_WALK;
        else if (fin) state_d = ST_HOLD;
      end
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_GATHER;
      sort_q      <= 1'b1;
      pkt_q.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pkt_q   <= pkt_d;
      if (clr) sort_q <= 1'b0;
    end
  end

  // Operation operands and sequencing registers
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      kind_q <= sotc_pkg::kind_e'(kind_i);
      a_q    <= first_name_i;
      b_q    <= second_name_i;
      if (sotc_pkg::kind_e'(kind_i) == sotc_pkg::K_ADD_PAIR) begin
        set_q <= sotc_pkg::set_t'(1) << second_name_i;
      end else begin
        set_q <= name_set_i & sotc_pkg::SET_LIVE;
      end
    end else begin
      set_q <= set_d;
    end
    cur_q <= cur_d;
    if (fin) begin
      fin_ok_q    <= fin_ok;
      fin_found_q <= fin_found;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_HOLD) && out_free) begin
      out_success_q <= fin_ok_q;
      out_sort_q    <= sort_q;
      out_found_q   <= fin_found_q;
      out_pres_q    <= sotc_pkg::set_t'(present_i);
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign pkt_o            = pkt_q;
  assign out_valid_o      = out_valid_q;
  assign success_o        = out_success_q;
  assign still_sortable_o = out_sort_q;
  assign found_o          = out_found_q;
  assign present_rows_o   = out_pres_q;

`ifndef SYNTH
  // Sortable never recovers once cleared
  a_sort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sort_q |=> !sort_q)
    else $error("sortable flag set again");

  // No transfer is launched while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pkt_q.valid)
    else $error("transfer launched while idle");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for strict_order_closure_table
// Drives order operations through the valid/stall input channel, predicts
// every result with a behavioural copy of the closure table and compares
// each result transfer field by field, under shifting idle and stall phases.
// Random adds follow a hidden ranking of the names, so the order stays
// consistent and the closure grows deep; the sticky sortable flag is only
// broken in a closing section, after which every update must fail.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [sotc_pkg::KIND_W-1:0] kind_t;

  // Kind codes the block leaves undefined
  localparam kind_t K_SPARE_LO = 3'd6;
  localparam kind_t K_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS = 350;
  localparam int PHASE_LEN  = 40;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    kind_t                kind;
    sotc_pkg::name_t      first;
    sotc_pkg::name_t      second;
    sotc_pkg::set_t       rights;
  } order_op_t;

  typedef struct packed {
    logic                 success;
    logic                 sortable;
    logic                 found;
    sotc_pkg::set_t       present;
  } verdict_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  kind_t                  kind_i         = '0;
  sotc_pkg::name_t        first_name_i   = '0;
  sotc_pkg::name_t        second_name_i  = '0;
  sotc_pkg::set_t         name_set_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic                   success_o;
  logic                   still_sortable_o;
  logic                   found_o;
  sotc_pkg::set_t         present_rows_o;

  strict_order_closure_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .first_name_i     (first_name_i),
    .second_name_i    (second_name_i),
    .name_set_i       (name_set_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .success_o        (success_o),
    .still_sortable_o (still_sortable_o),
    .found_o          (found_o),
    .present_rows_o   (present_rows_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  order_op_t pending_ops [$];
  verdict_t  expected_verdicts [$];
  int        mismatch_count = 0;
  int        taken_count    = 0;
  logic      op_taken       = 1'b0;
  logic      long_hold      = 1'b0;

  // --------------------------------------------------------------------------
  // Behavioural closure table
  // --------------------------------------------------------------------------
  sotc_pkg::row_t order_rows [sotc_pkg::NAMES];
  sotc_pkg::row_t owner_mask = '0;
  logic           order_ok   = 1'b1;

  initial begin
    for (int i = 0; i < sotc_pkg::NAMES; i++) order_rows[i] = '0;
  end

  function automatic logic holds_pair(sotc_pkg::name_t key, sotc_pkg::name_t val);
    return owner_mask[key] && order_rows[key][val];
  endfunction

  // lo precedes hi: hi and everything after hi joins lo and lo's predecessors
  function automatic logic link_names(sotc_pkg::name_t lo, sotc_pkg::name_t hi);
    sotc_pkg::row_t gain;
    int             i;
    if (!order_ok) return 1'b0;
    if (lo == hi || holds_pair(hi, lo)) begin
      order_ok = 1'b0;
      return 1'b0;
    end
    gain = sotc_pkg::row_t'(1) << hi;
    if (owner_mask[hi]) gain |= order_rows[hi];
    if (!owner_mask[lo]) begin
      owner_mask[lo] = 1'b1;
      order_rows[lo] = '0;
    end
    order_rows[lo] |= gain;
    for (i = 0; i < sotc_pkg::NAMES; i++)
      if (owner_mask[i] && order_rows[i][lo]) order_rows[i] |= gain;
    return 1'b1;
  endfunction

  function automatic void forget_name(sotc_pkg::name_t n);
    int i;
    owner_mask[n] = 1'b0;
    order_rows[n] = '0;
    for (i = 0; i < sotc_pkg::NAMES; i++) order_rows[i][n] = 1'b0;
  endfunction

  // src hands its relations over to dst and disappears
  function automatic logic merge_name(sotc_pkg::name_t src, sotc_pkg::name_t dst);
    if (!order_ok) return 1'b0;
    if (holds_pair(src, dst) || holds_pair(dst, src)) begin
      order_ok = 1'b0;
      return 1'b0;
    end
    if (!link_names(src, dst)) return 1'b0;
    order_rows[src][dst] = 1'b0;
    if (!link_names(dst, src)) return 1'b0;
    forget_name(src);
    return 1'b1;
  endfunction

  function automatic verdict_t apply_order_op(order_op_t op);
    verdict_t v;
    int       i;
    v = '0;
    case (op.kind)
      sotc_pkg::K_ADD_PAIR: v.success = link_names(op.first, op.second);
      sotc_pkg::K_ADD_SET: begin
        // ascending rights, stop at the first failure
        v.success = 1'b1;
        for (i = 0; i < sotc_pkg::SET_W && i < sotc_pkg::NAMES; i++)
          if (v.success && op.rights[i])
            v.success = link_names(op.first, sotc_pkg::name_t'(i));
      end
      sotc_pkg::K_RENAME: v.success = merge_name(op.first, op.second);
      sotc_pkg::K_REMOVE: begin
        if (order_ok) begin
          forget_name(op.first);
          v.success = 1'b1;
        end
      end
      sotc_pkg::K_QUERY_PAIR: begin
        v.found   = holds_pair(op.first, op.second);
        v.success = v.found;
      end
      sotc_pkg::K_QUERY_KEY: begin
        v.found   = owner_mask[op.first];
        v.success = v.found;
      end
      default: ;
    endcase
    v.sortable = order_ok;
    v.present  = sotc_pkg::set_t'(owner_mask);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus bookkeeping: a rank per name keeps random adds acyclic;
  // names outside in_use are known to have no relations at all.
  // --------------------------------------------------------------------------
  int                         name_rank [sotc_pkg::NAMES];
  logic [sotc_pkg::NAMES-1:0] in_use = '0;

  function automatic void queue_op(kind_t kind, sotc_pkg::name_t a, sotc_pkg::name_t b,
                                   sotc_pkg::set_t rights);
    order_op_t op;
    op.kind   = kind;
    op.first  = a;
    op.second = b;
    op.rights = rights;
    pending_ops.push_back(op);
    case (kind)
      sotc_pkg::K_ADD_PAIR: begin
        in_use[a] = 1'b1;
        in_use[b] = 1'b1;
      end
      sotc_pkg::K_ADD_SET:
        if (rights != '0) in_use = in_use | rights | (sotc_pkg::row_t'(1) << a);
      sotc_pkg::K_RENAME: begin
        name_rank[b] = name_rank[a];
        name_rank[a] = $urandom_range(31);
        in_use[a]    = 1'b0;
        in_use[b]    = 1'b1;
      end
      sotc_pkg::K_REMOVE: in_use[a] = 1'b0;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    order_op_t next_op;
    int        idle_pct;
    int        stall_pct;
    case ((taken_count / PHASE_LEN) % 4)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 70; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 17; stall_pct = 17; end
    endcase
    if (rst_ni && (!in_valid_i || op_taken)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_op        = pending_ops.pop_front();
        in_valid_i    <= 1'b1;
        kind_i        <= next_op.kind;
        first_name_i  <= next_op.first;
        second_name_i <= next_op.second;
        name_set_i    <= next_op.rights;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= long_hold || ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input transfer, check on output transfer
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    order_op_t seen;
    verdict_t  want;
    op_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.kind   = kind_i;
      seen.first  = first_name_i;
      seen.second = second_name_i;
      seen.rights = name_set_i;
      expected_verdicts.push_back(apply_order_op(seen));
      taken_count <= taken_count + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result transfer with none expected, got %b %b %b %0h", $time,
                 success_o, still_sortable_o, found_o, present_rows_o);
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("success", want.success, success_o);
        check_field("still_sortable", want.sortable, still_sortable_o);
        check_field("found", want.found, found_o);
        check_field("present_rows", want.present, present_rows_o);
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (taken_count >= 150);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int              roll;
    int              j;
    int              tries;
    sotc_pkg::name_t a;
    sotc_pkg::name_t b;
    sotc_pkg::name_t x;
    sotc_pkg::name_t y;
    sotc_pkg::set_t  allowed;
    logic            hit;

    for (j = 0; j < sotc_pkg::NAMES; j++) name_rank[j] = j;

    // Directed: empty table, chain building, extremes, spare kinds, rename
    queue_op(sotc_pkg::K_QUERY_KEY, 4'd0, 4'd0, '0);
    queue_op(sotc_pkg::K_QUERY_PAIR, 4'd15, 4'd0, '0);
    queue_op(sotc_pkg::K_ADD_SET, 4'd3, 4'd0, '0);          // empty set
    queue_op(sotc_pkg::K_ADD_PAIR, 4'd0, 4'd15, '0);
    queue_op(sotc_pkg::K_ADD_PAIR, 4'd0, 4'd1, '0);
    queue_op(sotc_pkg::K_ADD_PAIR, 4'd1, 4'd2, '0);
    queue_op(sotc_pkg::K_ADD_SET, 4'd4, 4'd0, 16'hFFE0);
    queue_op(sotc_pkg::K_ADD_PAIR, 4'd2, 4'd4, '0);         // closes through 0, 1, 2
    queue_op(sotc_pkg::K_QUERY_PAIR, 4'd0, 4'd15, '0);
    queue_op(sotc_pkg::K_QUERY_PAIR, 4'd15, 4'd0, '0);
    queue_op(sotc_pkg::K_QUERY_KEY, 4'd4, 4'd0, '0);
    queue_op(sotc_pkg::K_QUERY_KEY, 4'd15, 4'd15, '0);
    queue_op(K_SPARE_LO, 4'd15, 4'd15, 16'hFFFF);
    queue_op(K_SPARE_HI, 4'd0, 4'd0, '0);
    queue_op(sotc_pkg::K_RENAME, 4'd2, 4'd3, '0);
    queue_op(sotc_pkg::K_QUERY_PAIR, 4'd3, 4'd4, '0);
    queue_op(sotc_pkg::K_QUERY_KEY, 4'd2, 4'd0, '0);
    queue_op(sotc_pkg::K_REMOVE, 4'd15, 4'd0, '0);
    queue_op(sotc_pkg::K_ADD_PAIR, 4'd3, 4'd15, '0);
    queue_op(sotc_pkg::K_REMOVE, 4'd0, 4'd0, '0);
    queue_op(sotc_pkg::K_QUERY_KEY, 4'd0, 4'd0, '0);

    // Random, kept consistent with the ranking
    repeat (RANDOM_OPS) begin
      roll = $urandom_range(99);
      a    = sotc_pkg::name_t'($urandom_range(sotc_pkg::NAMES - 1));
      b    = sotc_pkg::name_t'($urandom_range(sotc_pkg::NAMES - 1));
      if (roll < 35) begin
        if (name_rank[a] == name_rank[b]) queue_op(sotc_pkg::K_QUERY_PAIR, a, b, '0);
        else if (name_rank[a] < name_rank[b]) queue_op(sotc_pkg::K_ADD_PAIR, a, b, '0);
        else queue_op(sotc_pkg::K_ADD_PAIR, b, a, '0);
      end else if (roll < 50) begin
        allowed = '0;
        for (j = 0; j < sotc_pkg::NAMES; j++) allowed[j] = name_rank[j] > name_rank[a];
        if ($urandom_range(15) == 0) queue_op(sotc_pkg::K_ADD_SET, a, b, allowed);
        else queue_op(sotc_pkg::K_ADD_SET, a, b,
                      sotc_pkg::set_t'($urandom & $urandom) & allowed);
      end else if (roll < 62) begin
        // rename only onto a name without relations
        hit = 1'b0;
        for (j = 0; j < sotc_pkg::NAMES; j++) begin
          y = sotc_pkg::name_t'(b + j);
          if (!hit && !in_use[y] && y != a) begin
            hit = 1'b1;
            x   = y;
          end
        end
        if (hit) queue_op(sotc_pkg::K_RENAME, a, x, sotc_pkg::set_t'($urandom));
        else queue_op(sotc_pkg::K_REMOVE, a, b, sotc_pkg::set_t'($urandom));
      end else if (roll < 72) begin
        queue_op(sotc_pkg::K_REMOVE, a, b, sotc_pkg::set_t'($urandom));
      end else if (roll < 85) begin
        queue_op(sotc_pkg::K_QUERY_PAIR, a, b, sotc_pkg::set_t'($urandom));
      end else if (roll < 95) begin
        queue_op(sotc_pkg::K_QUERY_KEY, a, b, sotc_pkg::set_t'($urandom));
      end else begin
        queue_op($urandom_range(1) ? K_SPARE_HI : K_SPARE_LO, a, b,
                 sotc_pkg::set_t'($urandom));
      end
    end

    // Closing section: one inconsistency, then every update must fail
    x     = 4'd0;
    y     = 4'd1;
    tries = 0;
    while (name_rank[x] == name_rank[y] && tries < 200) begin
      x = sotc_pkg::name_t'($urandom_range(sotc_pkg::NAMES - 1));
      y = sotc_pkg::name_t'($urandom_range(sotc_pkg::NAMES - 1));
      tries++;
    end
    if (name_rank[x] > name_rank[y]) begin
      a = x;
      x = y;
      y = a;
    end
    queue_op(sotc_pkg::K_ADD_PAIR, x, y, '0);
    case ($urandom_range(3))
      0:       queue_op(sotc_pkg::K_ADD_PAIR, x, x, '0);       // equal names
      1:       queue_op(sotc_pkg::K_ADD_PAIR, y, x, '0);       // reverse pair
      2:       queue_op(sotc_pkg::K_RENAME, x, y, '0);         // rename of related names
      default: queue_op(sotc_pkg::K_ADD_SET, y, x, 16'hFFFF);  // full set from the later name
    endcase
    queue_op(sotc_pkg::K_ADD_PAIR, 4'd0, 4'd15, '0);
    queue_op(sotc_pkg::K_ADD_PAIR, x, x, '0);
    queue_op(sotc_pkg::K_ADD_SET, x, y, 16'hFFFF);
    queue_op(sotc_pkg::K_RENAME, y, x, '0);
    queue_op(sotc_pkg::K_REMOVE, x, y, '0);
    queue_op(sotc_pkg::K_QUERY_PAIR, x, y, '0);
    queue_op(sotc_pkg::K_QUERY_KEY, x, y, '0);
    repeat (20)
      queue_op(kind_t'($urandom_range(7)), sotc_pkg::name_t'($urandom_range(15)),
               sotc_pkg::name_t'($urandom_range(15)), sotc_pkg::set_t'($urandom));

    // Reset, then let the driver and monitor run
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // checked on the rising edge, once the driver's updates have settled
    while (pending_ops.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (3 * sotc_pkg::NAMES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/sotc_pkg.sv
src/sotc_cell.sv
src/sotc_ctrl.sv
src/strict_order_closure_table.sv
verif/testbench.sv
